>>> src/bfsr_pkg.sv
// shared types and constants for the reachability matrix block
`timescale 1ns / 1ps

package bfsr_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int VTX_W        = 6;

  typedef logic [MAX_VERTICES-1:0] row_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [VTX_W-1:0]        vtx_t;

  localparam vtx_t COUNT_RESET = 6'd32;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DEL   = 2'd1,
    OP_QUERY = 2'd2,
    OP_REACH = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EDGE,
    ST_PICK,
    ST_MERGE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic any;
    idx_t idx;
    row_t rest;
  } pick_t;

endpackage

>>> src/bfs_reachability_matrix.sv
// Directed graph over an adjacency bit matrix with edge edit, query and reachability.
// Usage:
//   Input channel: an item (operation, from_vertex, to_vertex) is taken at a clock
//   edge with start high and busy low. Operations: add edge, delete edge, query
//   edge, reachability from from_vertex. Vertices are numbered from 1.
//   Config channel: cfg_data sets the vertex count, written when cfg_valid and
//   cfg_ready are high; cfg_ready is high whenever busy is low.
//   Result channel: each result sits on the result ports for one cycle with
//   result_valid high; last marks the final result of an item. The receiver
//   cannot stall, so results are never held.
// Timing:
//   Edge operations: check state, then edge state (row update or query);
//   errors: result formed in the check state. Results are registered onto the ports.
//   Reachability: check state, then per reached vertex a pick state (row read from the
//   edge store) and a merge state (merge into the visited set), then a pick state to
//   form the unreached set, then one result per cycle (at most 31).
//   The next item can be taken in the cycle that shows the last result.
// Reset: all edges cleared, vertex count 32, no result pending.
`timescale 1ns / 1ps

module bfs_reachability_matrix (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        operation,
  input  bfsr_pkg::vtx_t    from_vertex,
  input  bfsr_pkg::vtx_t    to_vertex,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  bfsr_pkg::vtx_t    cfg_data,
  output logic              result_valid,
  output logic              edge_present,
  output bfsr_pkg::vtx_t    unreachable_vertex,
  output logic              all_reachable,
  output logic              error,
  output logic              last
);
  import bfsr_pkg::*;

  state_t state, state_next;
  vtx_t   vertex_count;
  op_t    op;
  vtx_t   from_q, to_q;
  row_t   visited, visited_next;
  row_t   frontier, frontier_next;

  vtx_t   n;
  row_t   mask;
  logic   from_ok, to_ok;
  vtx_t   from_m1, to_m1;
  idx_t   from_idx, to_idx;
  row_t   to_bit;
  row_t   fresh;
  logic [IDX_W:0] vtx_p1;

  idx_t   rd_addr;
  row_t   rd_data;
  logic   wr_en;
  row_t   wr_data;
  pick_t  pick;

  logic   emit, e_present, e_all, e_err, e_last;
  vtx_t   e_vertex;

  bfsr_edge_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (from_idx),
    .wr_data (wr_data)
  );

  bfsr_pick u_pick (
    .word (frontier),
    .pick (pick)
  );

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = ~busy;

  // count above the matrix size acts as the matrix size
  always_comb begin
    if ({1'b0, vertex_count} > (VTX_W + 1)'(MAX_VERTICES)) begin
      n = vtx_t'(MAX_VERTICES);
    end else begin
      n = vertex_count;
    end
    for (int i = 0; i < MAX_VERTICES; i++) begin
      mask[i] = ((VTX_W + 1)'(i) < {1'b0, n});
    end
  end

  assign from_ok  = (from_q != '0) && (from_q <= n);
  assign to_ok    = (to_q != '0) && (to_q <= n);
  assign from_m1  = from_q - vtx_t'(1);
  assign to_m1    = to_q - vtx_t'(1);
  assign from_idx = from_m1[IDX_W-1:0];
  assign to_idx   = to_m1[IDX_W-1:0];
  assign to_bit   = row_t'(1) << to_idx;
  assign fresh    = rd_data & mask & ~visited;
  assign vtx_p1   = {1'b0, pick.idx} + (IDX_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      vertex_count <= COUNT_RESET;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= emit;
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      op     <= op_t'(operation);
      from_q <= from_vertex;
      to_q   <= to_vertex;
    end
    visited            <= visited_next;
    frontier           <= frontier_next;
    edge_present       <= e_present;
    unreachable_vertex <= e_vertex;
    all_reachable      <= e_all;
    error              <= e_err;
    last               <= e_last;
  end

  always_comb begin
    state_next    = state;
    visited_next  = visited;
    frontier_next = frontier;
    rd_addr       = from_idx;
    wr_en         = 1'b0;
    wr_data       = rd_data;
    emit          = 1'b0;
    e_present     = 1'b0;
    e_vertex      = '0;
    e_all         = 1'b0;
    e_err         = 1'b0;
    e_last        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (op == OP_REACH) begin
          if (!from_ok) begin
            emit       = 1'b1;
            e_err      = 1'b1;
            e_last     = 1'b1;
            state_next = ST_IDLE;
          end else begin
            visited_next  = row_t'(1) << from_idx;
            frontier_next = row_t'(1) << from_idx;
            state_next    = ST_PICK;
          end
        end else if (!(from_ok && to_ok)) begin
          emit       = 1'b1;
          e_err      = 1'b1;
          e_last     = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_EDGE;
        end
      end
      ST_EDGE: begin
        case (op)
          OP_ADD: begin
            wr_en   = 1'b1;
            wr_data = rd_data | to_bit;
          end
          OP_DEL: begin
            wr_en   = 1'b1;
            wr_data = rd_data & ~to_bit;
          end
          OP_QUERY: begin
            e_present = |(rd_data & to_bit);
          end
          default: begin
          end
        endcase
        emit       = 1'b1;
        e_last     = 1'b1;
        state_next = ST_IDLE;
      end
      ST_PICK: begin
        if (pick.any) begin
          rd_addr       = pick.idx;
          frontier_next = pick.rest;
          state_next    = ST_MERGE;
        end else begin
          // frontier now holds the vertices still to report
          frontier_next = ~visited & mask;
          state_next    = ST_EMIT;
        end
      end
      ST_MERGE: begin
        visited_next  = visited | fresh;
        frontier_next = frontier | fresh;
        state_next    = ST_PICK;
      end
      ST_EMIT: begin
        emit = 1'b1;
        if (!pick.any) begin
          e_all      = 1'b1;
          e_last     = 1'b1;
          state_next = ST_IDLE;
        end else begin
          e_vertex      = vtx_t'(vtx_p1);
          e_last        = (pick.rest == '0);
          frontier_next = pick.rest;
          if (pick.rest == '0) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/bfsr_edge_mem.sv
// adjacency row store with per-row valid bits and registered read
`timescale 1ns / 1ps

module bfsr_edge_mem (
  input  logic          clk,
  input  logic          rst,
  input  bfsr_pkg::idx_t rd_addr,
  output bfsr_pkg::row_t rd_data,
  input  logic          wr_en,
  input  bfsr_pkg::idx_t wr_addr,
  input  bfsr_pkg::row_t wr_data
);
  import bfsr_pkg::*;

  row_t                    mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;

  // a row never written reads as no edges
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= row_valid[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule

>>> src/bfsr_pick.sv
// lowest-set-bit picker shared by frontier expansion and result emission
`timescale 1ns / 1ps

module bfsr_pick (
  input  bfsr_pkg::row_t  word,
  output bfsr_pkg::pick_t pick
);
  import bfsr_pkg::*;

  always_comb begin
    pick.any  = |word;
    pick.idx  = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (word[i]) begin
        pick.idx = idx_t'(i);
      end
    end
    // clear the lowest set bit
    pick.rest = word & (word - row_t'(1));
  end

endmodule

>>> src/bfsr_checker.sv
// port-level checks for the reachability matrix block, bound to the top level
`timescale 1ns / 1ps

module bfsr_port_checks (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                result_valid,
  input bfsr_pkg::vtx_t      unreachable_vertex,
  input logic                all_reachable,
  input logic                error,
  input logic                last
);

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // an error result closes its item
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && error |-> last && !all_reachable && unreachable_vertex == '0)
    else $error("error result not final or not clean");

  // all-reachable is the final result of its item and names no vertex
  a_all_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && all_reachable |-> last && unreachable_vertex == '0)
    else $error("all-reachable result malformed");

  // more results follow a non-final one, so no new item can be taken yet
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> busy)
    else $error("idle while results still pending");

  // reported vertices rise strictly within one item
  a_ascending: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last ##1 result_valid |->
      unreachable_vertex > $past(unreachable_vertex))
    else $error("unreachable vertices not ascending");

endmodule

bind bfs_reachability_matrix bfsr_port_checks u_bfsr_port_checks (.*);
